// ===== src/btps_pkg.sv =====
// Shared types and constants for the binary trie prefix store.
package btps_pkg;

    localparam int unsigned KEY_W     = 32;   // key field width
    localparam int unsigned KEY_IDX_W = 5;    // bit index into the key
    localparam int unsigned LEN_W     = 6;    // key_len field width
    localparam int unsigned IN_W      = 40;   // s_tdata width, whole bytes
    localparam int unsigned OUT_W     = 8;    // m_tdata width, whole bytes

    localparam int unsigned NODE_COUNT_DEF = 1024;
    localparam int unsigned KEY_BITS_DEF   = 32;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_FIND   = 1'b1;

    // Request word as it sits in the front queue, length already saturated.
    typedef struct packed {
        logic             op;
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] len;
    } req_t;

endpackage

// ===== src/btps_front.sv =====
// Front end: accepts request words, clamps the key length and queues them.
module btps_front #(
    parameter int unsigned KEY_BITS = btps_pkg::KEY_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [btps_pkg::IN_W-1:0] s_tdata,
    input  logic                      s_tuser,
    output logic                      q_valid,
    input  logic                      q_ready,
    output btps_pkg::req_t            q_data
);

    localparam int unsigned LEN_W   = btps_pkg::LEN_W;
    localparam int unsigned KEY_W   = btps_pkg::KEY_W;
    localparam int unsigned LEN_MAX = (1 << LEN_W) - 1;
    localparam int unsigned SAT_LEN = (KEY_BITS > LEN_MAX) ? LEN_MAX : KEY_BITS;

    btps_pkg::req_t   q_mem_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic [LEN_W-1:0] raw_len;
    btps_pkg::req_t   in_req;
    logic             push, pop;

    // classify: pull fields apart, saturate length to the trie depth
    always_comb
    begin
        raw_len    = s_tdata[KEY_W +: LEN_W];
        in_req.op  = s_tuser;
        in_req.key = s_tdata[KEY_W-1:0];
        in_req.len = (raw_len > LEN_W'(SAT_LEN)) ? LEN_W'(SAT_LEN) : raw_len;
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = q_mem_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= in_req;
        end
    end

endmodule

// ===== src/btps_back.sv =====
// Back end: trie walk and node allocation over the node memory, result register.
module btps_back #(
    parameter int unsigned NODE_COUNT = btps_pkg::NODE_COUNT_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    output logic                       q_ready,
    input  btps_pkg::req_t             q_data,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [btps_pkg::OUT_W-1:0] m_tdata
);

    localparam int unsigned IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int unsigned NF_W  = IDX_W + 1;
    localparam int unsigned WORD_W = 2 * IDX_W;
    localparam int unsigned LEN_W = btps_pkg::LEN_W;
    localparam int unsigned KEY_W = btps_pkg::KEY_W;
    localparam int unsigned CMP_W = (NF_W > LEN_W) ? NF_W : LEN_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_ALLOC = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    // node memory: {right child, left child}
    logic [WORD_W-1:0] node_mem [NODE_COUNT];
    logic [WORD_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;

    logic [1:0]        state_reg, state_next;
    logic [NF_W-1:0]   nf_reg, nf_next;
    logic              m_valid_reg, m_valid_next;
    logic              op_reg, op_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic              found_reg, found_next;
    logic              full_reg, full_next;
    logic              m_found_reg, m_found_next;
    logic              m_full_reg, m_full_next;

    logic              kbit;
    logic [WORD_W-1:0] cur_word;
    logic [IDX_W-1:0]  child;
    logic [LEN_W-1:0]  need;
    logic [NF_W-1:0]   avail;
    logic [IDX_W-1:0]  nf_idx;
    logic              out_free;

    assign kbit     = (idx_reg < LEN_W'(KEY_W)) ? key_reg[idx_reg[btps_pkg::KEY_IDX_W-1:0]]
                                                : 1'b0;
    // root reads empty until the first node has been handed out
    assign cur_word = ((pos_reg == '0) && (nf_reg == NF_W'(1))) ? '0 : rd_data_reg;
    assign child    = kbit ? cur_word[WORD_W-1:IDX_W] : cur_word[IDX_W-1:0];
    assign need     = len_reg - idx_reg;
    assign avail    = NF_W'(NODE_COUNT) - nf_reg;
    assign nf_idx   = nf_reg[IDX_W-1:0];
    assign out_free = !m_valid_reg || m_tready;

    assign q_ready  = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(btps_pkg::OUT_W-2){1'b0}}, m_full_reg, m_found_reg};

    always_comb
    begin
        state_next   = state_reg;
        nf_next      = nf_reg;
        m_valid_next = m_valid_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        len_next     = len_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        word_next    = word_reg;
        found_next   = found_reg;
        full_next    = full_reg;
        m_found_next = m_found_reg;
        m_full_next  = m_full_reg;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = pos_reg;
        wr_data      = word_reg;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    op_next    = q_data.op;
                    key_next   = q_data.key;
                    len_next   = q_data.len;
                    idx_next   = '0;
                    pos_next   = '0;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (idx_reg == len_reg)
                begin
                    found_next = 1'b1;
                    full_next  = 1'b0;
                    state_next = S_DONE;
                end
                else if (child != '0)
                begin
                    pos_next = child;
                    idx_next = idx_reg + LEN_W'(1);
                    rd_addr  = child;
                end
                else if (op_reg == btps_pkg::OP_FIND)
                begin
                    found_next = 1'b0;
                    full_next  = 1'b0;
                    state_next = S_DONE;
                end
                else if (CMP_W'(need) > CMP_W'(avail))
                begin
                    found_next = 1'b0;
                    full_next  = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    word_next  = cur_word;
                    state_next = S_ALLOC;
                end
            end
            S_ALLOC:
            begin
                wr_en = 1'b1;
                if (idx_reg != len_reg)
                begin
                    // hook the next free node under the current one
                    wr_data  = kbit ? {nf_idx, word_reg[IDX_W-1:0]}
                                    : {word_reg[WORD_W-1:IDX_W], nf_idx};
                    pos_next  = nf_idx;
                    nf_next   = nf_reg + NF_W'(1);
                    idx_next  = idx_reg + LEN_W'(1);
                    word_next = '0;
                end
                else
                begin
                    // leaf: clear both children of the last new node
                    wr_data    = word_reg;
                    found_next = 1'b0;
                    full_next  = 1'b0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_found_next = found_reg;
                    m_full_next  = full_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            nf_reg      <= NF_W'(1);
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            nf_reg      <= nf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        len_reg     <= len_next;
        idx_reg     <= idx_next;
        pos_reg     <= pos_next;
        word_reg    <= word_next;
        found_reg   <= found_next;
        full_reg    <= full_next;
        m_found_reg <= m_found_next;
        m_full_reg  <= m_full_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            node_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= node_mem[rd_addr];
    end

    a_nf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nf_reg <= NF_W'(NODE_COUNT))
        else $error("free counter ran past the pool");

    a_nf_step: assert property (@(posedge clk) disable iff (!rst_n)
        (nf_reg != $past(nf_reg)) |-> (nf_reg == $past(nf_reg) + NF_W'(1)))
        else $error("free counter moved by more than one node");

    a_walk_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK || state_reg == S_ALLOC) |-> (NF_W'(pos_reg) < nf_reg))
        else $error("walk reached a node that was never allocated");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK || state_reg == S_ALLOC) |-> (idx_reg <= len_reg))
        else $error("bit index past key length");

endmodule

// ===== src/binary_trie_prefix_store_unit.sv =====
// Top level of the binary trie prefix store: front queue plus walk engine.
// Usage:
//   Slave channel (s_*) takes one request word per handshake: s_tuser is the
//   opcode (0 insert, 1 find), s_tdata carries key and key_len. Master
//   channel (m_*) returns exactly one result word per request, in order:
//   found in bit 0, pool_full in bit 1. key_len above KEY_BITS is clamped.
//   An insert that cannot get all the nodes it needs from the pool changes
//   nothing and reports pool_full.
// Timing:
//   Keys are walked from bit 0 upward, one node memory read per key bit.
//   The result word appears in the same cycle that the engine is ready to
//   take the next request; requests are processed one at a time.
//   The front queue holds two requests, so the slave side keeps accepting
//   while the engine works or the result waits on m_tready.
// Reset and stalls:
//   rst_n clears the queue, the result valid flag and the free counter; the
//   trie reads empty right after reset, no clearing pass is needed. A stalled
//   receiver holds the result word, the engine waits, then s_tready drops.
module binary_trie_prefix_store_unit #(
    parameter int unsigned NODE_COUNT = btps_pkg::NODE_COUNT_DEF,
    parameter int unsigned KEY_BITS   = btps_pkg::KEY_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [btps_pkg::IN_W-1:0]  s_tdata,  // key[31:0], key_len[37:32], zero pad
    input  logic                       s_tuser,  // opcode
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [btps_pkg::OUT_W-1:0] m_tdata   // found[0], pool_full[1], zero pad
);

    logic           q_valid;
    logic           q_ready;
    btps_pkg::req_t q_data;

    btps_front #(
        .KEY_BITS (KEY_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data)
    );

    btps_back #(
        .NODE_COUNT (NODE_COUNT)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== tb/tb_binary_trie_prefix_store_unit.sv =====
// Testbench for the trie prefix store: directed table, then random words on a local model.
`timescale 1ns / 1ps

module tb_binary_trie_prefix_store_unit;

    localparam int unsigned KEY_W       = btps_pkg::KEY_W;
    localparam int unsigned LEN_W       = btps_pkg::LEN_W;
    localparam int unsigned IN_W        = btps_pkg::IN_W;
    localparam int unsigned OUT_W       = btps_pkg::OUT_W;
    localparam int unsigned POOL_NODES  = btps_pkg::NODE_COUNT_DEF;
    localparam int unsigned PATH_BITS   = btps_pkg::KEY_BITS_DEF;
    localparam int unsigned NODE_W      = $clog2(POOL_NODES);
    localparam int unsigned PAD_W       = IN_W - KEY_W - LEN_W;
    localparam int unsigned IDLE_MAX    = 11;
    localparam int unsigned HOLD_CYCLES = 300;     // long receiver stall
    localparam int unsigned TAIL_CYCLES = 120;     // > worst insert latency
    localparam int unsigned DRAIN_LIMIT = 20000;
    localparam int unsigned SEEN_MAX    = 64;
    localparam int unsigned DIRECTED_N  = 20;

    // Expected result word.
    typedef struct packed {
        logic pool_full;
        logic found;
    } result_t;

    // One row of the directed table; typed rows carry a hand-written result.
    typedef struct packed {
        logic             op;
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] len;
        logic             typed;
        logic             found;
        logic             pool_full;
    } row_t;

    // A path already inserted, reused to steer finds and extensions.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] len;
    } path_t;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;   // key[31:0], key_len[37:32], zero pad
    logic             s_tuser  = btps_pkg::OP_INSERT;   // opcode
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;         // found[0], pool_full[1], zero pad

    // Local copy of the trie.
    logic [NODE_W-1:0] trie_left  [POOL_NODES];
    logic [NODE_W-1:0] trie_right [POOL_NODES];
    logic [NODE_W:0]   trie_next_free;

    result_t     pending_results [$];
    path_t       seen_paths [$];
    int unsigned mismatch_count = 0;
    bit          no_idle = 1'b0;       // both sides run without gaps
    bit          hold_rx = 1'b0;       // ask receiver for a long stall

    row_t directed_rows [DIRECTED_N] = '{
        // empty path after reset
        '{btps_pkg::OP_FIND,   32'h0000_0000, 6'd0,  1'b1, 1'b1, 1'b0},
        // empty trie: nothing found
        '{btps_pkg::OP_FIND,   32'hFFFF_FFFF, 6'd32, 1'b1, 1'b0, 1'b0},
        '{btps_pkg::OP_INSERT, 32'hFFFF_FFFF, 6'd32, 1'b1, 1'b0, 1'b0},
        '{btps_pkg::OP_FIND,   32'hFFFF_FFFF, 6'd32, 1'b1, 1'b1, 1'b0},
        // length above KEY_BITS clamps: existing path
        '{btps_pkg::OP_INSERT, 32'hFFFF_FFFF, 6'd63, 1'b1, 1'b1, 1'b0},
        '{btps_pkg::OP_FIND,   32'hFFFF_FFFF, 6'd63, 1'b1, 1'b1, 1'b0},
        // empty insert changes nothing
        '{btps_pkg::OP_INSERT, 32'h0000_0000, 6'd0,  1'b1, 1'b1, 1'b0},
        '{btps_pkg::OP_INSERT, 32'h0000_0000, 6'd32, 1'b1, 1'b0, 1'b0},
        '{btps_pkg::OP_FIND,   32'h0000_FFFF, 6'd16, 1'b0, 1'b0, 1'b0},
        '{btps_pkg::OP_FIND,   32'h0000_0001, 6'd1,  1'b0, 1'b0, 1'b0},
        '{btps_pkg::OP_INSERT, 32'hA5A5_A5A5, 6'd20, 1'b0, 1'b0, 1'b0},
        '{btps_pkg::OP_FIND,   32'hA5A5_A5A5, 6'd21, 1'b0, 1'b0, 1'b0},
        '{btps_pkg::OP_INSERT, 32'hA5A5_A5A5, 6'd40, 1'b0, 1'b0, 1'b0},
        '{btps_pkg::OP_FIND,   32'h5A5A_5A5A, 6'd32, 1'b0, 1'b0, 1'b0},
        '{btps_pkg::OP_INSERT, 32'h8000_0000, 6'd32, 1'b0, 1'b0, 1'b0},
        '{btps_pkg::OP_FIND,   32'h8000_0000, 6'd31, 1'b0, 1'b0, 1'b0},
        '{btps_pkg::OP_FIND,   32'h7FFF_FFFF, 6'd32, 1'b0, 1'b0, 1'b0},
        '{btps_pkg::OP_INSERT, 32'hFFFF_FFFE, 6'd1,  1'b0, 1'b0, 1'b0},
        // empty path on find, any key
        '{btps_pkg::OP_FIND,   32'hDEAD_BEEF, 6'd0,  1'b1, 1'b1, 1'b0},
        '{btps_pkg::OP_INSERT, 32'h1234_5678, 6'd33, 1'b0, 1'b0, 1'b0}
    };

    binary_trie_prefix_store_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        for (int unsigned n = 0; n < POOL_NODES; n++)
        begin
            trie_left[n]  = '0;
            trie_right[n] = '0;
        end
        trie_next_free = (NODE_W+1)'(1);
    end

    // Walk the trie LSB first; an insert grabs fresh nodes for the missing
    // tail or is refused whole when the pool is short.
    function automatic result_t trie_walk(input logic op, input logic [KEY_W-1:0] key,
                                          input logic [LEN_W-1:0] len_in);
        result_t           res;
        int unsigned       len;
        int unsigned       i;
        int unsigned       avail;
        logic [NODE_W-1:0] pos;
        logic [NODE_W-1:0] nx;
        len = (len_in > PATH_BITS) ? PATH_BITS : len_in;
        pos = '0;
        i   = 0;
        while (i < len)
        begin
            nx = key[i] ? trie_right[pos] : trie_left[pos];
            if (nx == '0)
                break;
            pos = nx;
            i++;
        end
        res.found     = (i == len);
        res.pool_full = 1'b0;
        if (op == btps_pkg::OP_INSERT && i != len)
        begin
            avail = (trie_next_free < POOL_NODES) ? POOL_NODES - trie_next_free : 0;
            if (len - i > avail)
            begin
                res.pool_full = 1'b1;
            end
            else
            begin
                while (i < len)
                begin
                    if (key[i])
                        trie_right[pos] = trie_next_free[NODE_W-1:0];
                    else
                        trie_left[pos] = trie_next_free[NODE_W-1:0];
                    pos            = trie_next_free[NODE_W-1:0];
                    trie_next_free = trie_next_free + 1'b1;
                    i++;
                end
            end
        end
        return res;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    function automatic int unsigned idle_draw();
        return no_idle ? 0 : $urandom_range(IDLE_MAX, 0);
    endfunction

    // Offer one request word; valid stays high after the handshake so a
    // back-to-back word needs no second assignment in the same step.
    task automatic send_request(input logic op, input logic [KEY_W-1:0] key,
                                input logic [LEN_W-1:0] len, input logic typed,
                                input result_t typed_res);
        int unsigned gap;
        result_t     predicted;
        gap = idle_draw();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{PAD_W{1'b0}}, len, key};
        do @(posedge clk); while (!s_tready);
        predicted = trie_walk(op, key, len);
        pending_results.push_back(typed ? typed_res : predicted);
        if (op == btps_pkg::OP_INSERT && len != 0)
        begin
            if (seen_paths.size() < SEEN_MAX)
                seen_paths.push_back(path_t'{key,
                                             (len > PATH_BITS) ? LEN_W'(PATH_BITS) : len});
            else
                seen_paths[$urandom_range(SEEN_MAX - 1, 0)] =
                    path_t'{key, (len > PATH_BITS) ? LEN_W'(PATH_BITS) : len};
        end
    endtask

    // Sender pause: hold off until every result is back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Random words: about half built on paths of earlier inserts, some fresh keys,
    // a little noise over the full length range.
    task automatic random_burst(input int unsigned count, input int unsigned ins_pct,
                                input int unsigned len_lo, input int unsigned len_hi,
                                input bit with_hold);
        logic             op;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] scramble;
        logic [LEN_W-1:0] len;
        path_t            base;
        int unsigned      style;
        int unsigned      cut;
        for (int unsigned n = 0; n < count; n++)
        begin
            no_idle = (n >= count / 3) && (n < count / 3 + 40);
            if (with_hold && n == count / 3)
                hold_rx = 1'b1;
            op       = ($urandom_range(99, 0) < ins_pct) ? btps_pkg::OP_INSERT
                                                         : btps_pkg::OP_FIND;
            style    = $urandom_range(9, 0);
            scramble = $urandom();
            key      = $urandom();
            len      = LEN_W'($urandom_range(len_hi, len_lo));
            if (style < 5 && seen_paths.size() != 0)
            begin
                base = seen_paths[$urandom_range(seen_paths.size() - 1, 0)];
                if (op == btps_pkg::OP_FIND)
                begin
                    // prefix of a stored path, junk above it
                    len = LEN_W'($urandom_range(base.len, 0));
                    key = base.key ^ (scramble << len);
                end
                else
                begin
                    // branch off a stored path somewhere along it
                    cut = $urandom_range(base.len, 0);
                    key = base.key ^ (scramble << cut);
                end
            end
            else if (style == 8)
            begin
                len = LEN_W'($urandom_range(63, 0));
            end
            else if (style == 9)
            begin
                key = scramble[0] ? '1 : '0;
                key = key ^ (KEY_W'(1) << $urandom_range(KEY_W - 1, 0));
            end
            send_request(op, key, len, 1'b0, '0);
        end
        no_idle = 1'b0;
    endtask

    // Receiver: random stalls per word, one long stall on request.
    initial
    begin : rx_side
        int unsigned gap;
        result_t     want;
        @(posedge rst_n);
        forever
        begin
            if (hold_rx)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rx = 1'b0;
                gap     = 0;
            end
            else
            begin
                gap = idle_draw();
            end
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            if (pending_results.size() == 0)
            begin
                flag_mismatch($sformatf("result word with nothing pending, tdata=%h", m_tdata));
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[0] !== want.found)
                    flag_mismatch($sformatf("found got %b want %b", m_tdata[0], want.found));
                if (m_tdata[1] !== want.pool_full)
                    flag_mismatch($sformatf("pool_full got %b want %b",
                                            m_tdata[1], want.pool_full));
            end
        end
    end

    initial
    begin : tx_side
        int unsigned waited;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
            send_request(directed_rows[r].op, directed_rows[r].key, directed_rows[r].len,
                         directed_rows[r].typed,
                         '{directed_rows[r].pool_full, directed_rows[r].found});
        wait_drained();

        // shallow trie, lots of shared prefixes
        random_burst(350, 60, 0, 10, 1'b0);
        wait_drained();
        // long inserts run the pool dry, receiver stalls midway
        random_burst(300, 85, 14, 40, 1'b1);
        wait_drained();
        // full pool: short tails near the edge, refusals, finds
        random_burst(380, 50, 0, 63, 1'b1);

        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== binary_trie_prefix_store_unit.f =====
src/btps_pkg.sv
src/btps_front.sv
src/btps_back.sv
src/binary_trie_prefix_store_unit.sv
tb/tb_binary_trie_prefix_store_unit.sv
